/* src/asp_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the arc spread
// point generator. No dependencies.
`timescale 1ns / 1ps

package asp_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int ANGLE_BITS   = 16;
    localparam int COORD_BITS   = 24;
    localparam int CORDIC_ITERS = 24;
    localparam int DIV_STEPS    = 22;
    localparam int CW           = 52;
    localparam int ZW           = 34;

    localparam logic [1:0] OP_SPREAD = 2'd0;
    localparam logic [1:0] OP_FIXED  = 2'd1;
    localparam logic [1:0] OP_AIM    = 2'd2;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_ARC_SPAN    = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic [22:0]        radial_offset;
        logic [15:0]        rotation;
        logic [15:0]        fixed_heading;
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
    } t_in;

    typedef struct packed {
        logic [5:0]         point_index;
        logic [15:0]        heading;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic               last;
    } t_out;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic sc_init;
        logic at_init;
        logic cor_step;
        logic mul;
        logic acc;
        logic axis;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic div_done;
        logic cor_done;
        logic aim;
        logic last_pt;
        logic out_ready;
    } t_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_DIVI,
        ST_DIV,
        ST_ANG,
        ST_SC,
        ST_MULX,
        ST_ACCX,
        ST_MULY,
        ST_ACCY,
        ST_ATI,
        ST_AT,
        ST_OUT
    } t_state;

    function automatic logic [29:0] atan_val(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/asp_ctrl.sv */
// Sequencer for the arc spread point generator.
// Depends on asp_pkg; drives asp_dp through t_cmd and reads t_sts.
`timescale 1ns / 1ps

module asp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  asp_pkg::t_sts i_sts,
    output asp_pkg::t_cmd o_cmd
);

    asp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != asp_pkg::ST_IDLE);
        case (r_state)
            asp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = asp_pkg::ST_CHK;
                end
            end
            asp_pkg::ST_CHK: begin
                n_state = i_sts.n_zero ? asp_pkg::ST_IDLE : asp_pkg::ST_DIVI;
            end
            asp_pkg::ST_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = asp_pkg::ST_DIV;
            end
            asp_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = asp_pkg::ST_ANG;
            end
            asp_pkg::ST_ANG: begin
                o_cmd.sc_init = 1'b1;
                n_state       = asp_pkg::ST_SC;
            end
            asp_pkg::ST_SC: begin
                o_cmd.cor_step = 1'b1;
                if (i_sts.cor_done) n_state = asp_pkg::ST_MULX;
            end
            asp_pkg::ST_MULX: begin
                o_cmd.mul = 1'b1;
                n_state   = asp_pkg::ST_ACCX;
            end
            asp_pkg::ST_ACCX: begin
                o_cmd.acc = 1'b1;
                n_state   = asp_pkg::ST_MULY;
            end
            asp_pkg::ST_MULY: begin
                o_cmd.mul  = 1'b1;
                o_cmd.axis = 1'b1;
                n_state    = asp_pkg::ST_ACCY;
            end
            asp_pkg::ST_ACCY: begin
                o_cmd.acc  = 1'b1;
                o_cmd.axis = 1'b1;
                n_state    = i_sts.aim ? asp_pkg::ST_ATI : asp_pkg::ST_OUT;
            end
            asp_pkg::ST_ATI: begin
                o_cmd.at_init = 1'b1;
                n_state       = asp_pkg::ST_AT;
            end
            asp_pkg::ST_AT: begin
                o_cmd.cor_step = 1'b1;
                if (i_sts.cor_done) n_state = asp_pkg::ST_OUT;
            end
            asp_pkg::ST_OUT: begin
                if (i_sts.out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = i_sts.last_pt ? asp_pkg::ST_IDLE : asp_pkg::ST_DIVI;
                end
            end
            default: begin
                n_state = asp_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_ready)
        else $error("result loaded while output register busy");
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.div_step, o_cmd.cor_step, o_cmd.mul, o_cmd.acc, o_cmd.out_load}))
        else $error("datapath operations overlap");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && i_sts.last_pt) |=> !o_stall)
        else $error("not idle after final point");
`endif

endmodule

/* src/asp_dp.sv */
// Datapath: config registers, step divider, shared CORDIC, offset multiplier
// and output register. Depends on asp_pkg; driven by asp_ctrl.
`timescale 1ns / 1ps

module asp_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  asp_pkg::t_in  i_in,
    input  asp_pkg::t_cmd i_cmd,
    output asp_pkg::t_sts o_sts,
    output logic          o_valid,
    input  logic          i_stall,
    output asp_pkg::t_out o_out
);

    logic [6:0]  r_point_count;
    logic [15:0] r_arc_span;

    logic [1:0]         r_mode;
    logic signed [23:0] r_ox, r_oy, r_tx, r_ty;
    logic [22:0]        r_r;
    logic [15:0]        r_rot, r_fixed, r_span;
    logic [6:0]         r_n;
    logic [5:0]         r_idx;
    logic [4:0]         r_iter;

    logic [21:0] r_num, r_quo;
    logic [6:0]  r_rem;

    logic [15:0]          r_ang;
    logic signed [51:0]   r_cx, r_cy;
    logic signed [33:0]   r_cz;
    logic                 r_vec, r_flip, r_zero_vec;
    logic [31:0]          r_base;
    logic signed [57:0]   r_prod;
    logic signed [23:0]   r_sx, r_sy;

    logic         r_o_valid;
    asp_pkg::t_out r_out;

    logic [5:0]  div_d;
    logic [6:0]  div_t;
    logic        n_one;
    logic [15:0] ang;
    logic [31:0] sc_p, sc_q, sc_p2;
    logic        sc_flip;
    logic signed [24:0] dx, dy;
    logic signed [51:0] ax, ay;
    logic        ccw;
    logic signed [51:0] xs, ys;
    logic signed [33:0] atan_e;
    logic signed [51:0] mop;
    logic signed [33:0] mop34;
    logic signed [57:0] rnd, shr;
    logic signed [23:0] org;
    logic signed [28:0] sum;
    logic signed [23:0] sat;
    logic [31:0] ph;
    logic [31:0] ph_r;
    logic [15:0] head;
    logic [6:0]  n_eff;

    assign n_eff  = (r_point_count > 7'(asp_pkg::MAX_POINTS)) ?
                    7'(asp_pkg::MAX_POINTS) : r_point_count;
    assign div_d  = 6'(r_n - 7'd1);
    assign n_one  = (r_n == 7'd1);
    assign div_t  = {r_rem[5:0], r_num[21]};
    assign ang    = r_rot - {1'b0, r_span[15:1]} + (n_one ? 16'd0 : r_quo[15:0]);
    assign sc_p   = {ang, 16'h0};
    assign sc_q   = sc_p + 32'h4000_0000;
    assign sc_flip = sc_q[31];
    assign sc_p2  = sc_flip ? sc_p - 32'h8000_0000 : sc_p;
    assign dx     = 25'(r_tx) - 25'(r_sx);
    assign dy     = 25'(r_ty) - 25'(r_sy);
    assign ax     = {{3{dx[24]}}, dx, 24'h0};
    assign ay     = {{3{dy[24]}}, dy, 24'h0};
    assign ccw    = r_vec ? !(r_cy > 52'sd0) : (r_cz >= 34'sd0);
    assign xs     = r_cx >>> r_iter;
    assign ys     = r_cy >>> r_iter;
    assign atan_e = $signed({4'b0, asp_pkg::atan_val(r_iter)});
    assign mop    = r_flip ? -(i_cmd.axis ? r_cy : r_cx) : (i_cmd.axis ? r_cy : r_cx);
    assign mop34  = mop[33:0];
    assign rnd    = r_prod + 58'sd536870912;
    assign shr    = rnd >>> 30;
    assign org    = i_cmd.axis ? r_oy : r_ox;
    assign sum    = 29'(org) + shr[28:0];
    assign sat    = (sum > 29'sd8388607) ? 24'sh7FFFFF :
                    (sum < -29'sd8388608) ? 24'sh800000 : sum[23:0];
    assign ph     = r_zero_vec ? 32'h0 : r_base + r_cz[31:0];
    assign ph_r   = ph + 32'h0000_8000;

    always_comb begin
        case (r_mode)
            asp_pkg::OP_FIXED: head = r_fixed;
            asp_pkg::OP_AIM:   head = ph_r[31:16];
            default:           head = r_ang;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 7'd1;
            r_arc_span    <= 16'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == asp_pkg::CFG_POINT_COUNT) r_point_count <= i_cfg_data[6:0];
            if (i_cfg_index == asp_pkg::CFG_ARC_SPAN)    r_arc_span    <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_in.opcode;
            r_ox    <= i_in.origin_x;
            r_oy    <= i_in.origin_y;
            r_r     <= i_in.radial_offset;
            r_rot   <= i_in.rotation;
            r_fixed <= i_in.fixed_heading;
            r_tx    <= i_in.target_x;
            r_ty    <= i_in.target_y;
            r_span  <= r_arc_span;
            r_n     <= n_eff;
            r_idx   <= 6'd0;
        end
        if (i_cmd.div_init) begin
            r_num  <= r_idx * r_span;
            r_rem  <= 7'd0;
            r_quo  <= 22'd0;
            r_iter <= 5'd0;
        end
        if (i_cmd.div_step) begin
            r_num  <= {r_num[20:0], 1'b0};
            r_iter <= r_iter + 5'd1;
            if (div_t >= {1'b0, div_d}) begin
                r_rem <= div_t - {1'b0, div_d};
                r_quo <= {r_quo[20:0], 1'b1};
            end else begin
                r_rem <= div_t;
                r_quo <= {r_quo[20:0], 1'b0};
            end
        end
        if (i_cmd.sc_init) begin
            r_ang  <= ang;
            r_cx   <= 52'sd652032874;
            r_cy   <= 52'sd0;
            r_cz   <= {{2{sc_p2[31]}}, sc_p2};
            r_flip <= sc_flip;
            r_vec  <= 1'b0;
            r_iter <= 5'd0;
        end
        if (i_cmd.at_init) begin
            r_cx       <= dx[24] ? -ax : ax;
            r_cy       <= dx[24] ? -ay : ay;
            r_cz       <= 34'sd0;
            r_base     <= dx[24] ? 32'h8000_0000 : 32'h0;
            r_zero_vec <= (dx == 25'sd0) && (dy == 25'sd0);
            r_vec      <= 1'b1;
            r_iter     <= 5'd0;
        end
        if (i_cmd.cor_step) begin
            r_iter <= r_iter + 5'd1;
            if (ccw) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - atan_e;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + atan_e;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= mop34 * $signed({1'b0, r_r});
        end
        if (i_cmd.acc) begin
            if (i_cmd.axis) r_sy <= sat;
            else            r_sx <= sat;
        end
        if (i_cmd.out_load) begin
            r_out.point_index <= r_idx;
            r_out.heading     <= head;
            r_out.start_x     <= r_sx;
            r_out.start_y     <= r_sy;
            r_out.last        <= o_sts.last_pt;
            r_idx             <= r_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_sts.n_zero    = (r_n == 7'd0);
    assign o_sts.div_done  = (r_iter == 5'(asp_pkg::DIV_STEPS - 1));
    assign o_sts.cor_done  = (r_iter == 5'(asp_pkg::CORDIC_ITERS - 1));
    assign o_sts.aim       = (r_mode == asp_pkg::OP_AIM);
    assign o_sts.last_pt   = ({1'b0, r_idx} + 7'd1 == r_n);
    assign o_sts.out_ready = !r_o_valid || !i_stall;
    assign o_valid         = r_o_valid;
    assign o_out           = r_out;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && !n_one) |-> (r_rem < {1'b0, div_d}))
        else $error("divider remainder out of range");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cor_step |-> (r_iter < 5'(asp_pkg::CORDIC_ITERS)))
        else $error("cordic step count overrun");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> ({1'b0, r_idx} < r_n))
        else $error("point index beyond count");
`endif

endmodule

/* src/arc_spread_point_generator.sv */
// Top level of the arc spread point generator: joins asp_ctrl and asp_dp.
// Depends on asp_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------
//  request  | i_valid / o_stall  | i_in  (asp_pkg::t_in)
//  point    | o_valid / i_stall  | o_out (asp_pkg::t_out)
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Each point runs the step divider, the CORDIC rotation and the multiply and
// accumulate for x and y, then in aimed mode a second CORDIC pass; each request
// is first accepted and its point count checked.
// A request is taken only when idle; the finished point waits in an output
// register so work on the next point goes on while the receiver stalls.
// Synchronous active-low reset; point_count resets to 1, arc_span to 0.
`timescale 1ns / 1ps

module arc_spread_point_generator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  asp_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output asp_pkg::t_out o_out
);

    asp_pkg::t_cmd cmd;
    asp_pkg::t_sts sts;

    asp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    asp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for arc_spread_point_generator: drives fire requests and
// config writes, predicts every point with a local CORDIC model. Needs asp_pkg.
`timescale 1ns / 1ps

module tb;
    import asp_pkg::*;

    localparam int CLK_HALF = 5;
    localparam int WD_LIMIT = 60000;
    localparam int SETTLE   = 200;
    localparam int N_RANDOM = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    t_in         i_in;
    logic        o_valid;
    logic        i_stall;
    t_out        o_out;

    arc_spread_point_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out)
    );

    t_in  req_q[$];
    t_out point_q[$];
    int   n_fail;
    bit   calm;
    int   hold_off;
    int   gap_cnt;
    int   stall_cnt;
    int   idle_cycles;
    int   cfg_count;
    int   cfg_span;

    localparam longint ATAN_TAB[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    task automatic rotate_phase(input bit [31:0] p, output longint c, output longint s);
        bit     flip;
        longint x, y, z, nx, ny;
        flip = 0;
        x = 652032874;
        y = 0;
        if (((p + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            p = p - 32'h8000_0000;
            flip = 1;
        end
        z = longint'($signed(p));
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i);
                ny = y + fshr(x, i);
                z -= ATAN_TAB[i];
            end else begin
                nx = x + fshr(y, i);
                ny = y - fshr(x, i);
                z += ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic bit [31:0] aim_phase(longint dx, longint dy);
        longint    x, y, z, nx, ny;
        bit [31:0] base;
        if (dx == 0 && dy == 0) return 0;
        x = dx * 64'sd16777216;
        y = dy * 64'sd16777216;
        z = 0;
        base = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            base = 32'h8000_0000;
        end
        for (int i = 0; i < 24; i++) begin
            if (y > 0) begin
                nx = x + fshr(y, i);
                ny = y - fshr(x, i);
                z += ATAN_TAB[i];
            end else begin
                nx = x - fshr(y, i);
                ny = y + fshr(x, i);
                z -= ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return base + z[31:0];
    endfunction

    task automatic predict_points(input t_in rq);
        int        n;
        bit [15:0] span, ang, step;
        longint    c, s, sx, sy, r;
        t_out      pt;
        bit [31:0] ph;
        n = (cfg_count > MAX_POINTS) ? MAX_POINTS : cfg_count;
        span = cfg_span[15:0];
        r = longint'(rq.radial_offset);
        for (int i = 0; i < n; i++) begin
            step = (n > 1) ? 16'((longint'(i) * span) / (n - 1)) : 16'd0;
            ang = rq.rotation - (span >> 1) + step;
            rotate_phase({ang, 16'd0}, c, s);
            sx = clamp_coord(longint'(rq.origin_x) + fshr(c * r + (64'sd1 <<< 29), 30));
            sy = clamp_coord(longint'(rq.origin_y) + fshr(s * r + (64'sd1 <<< 29), 30));
            pt.point_index = 6'(i);
            pt.start_x = sx[23:0];
            pt.start_y = sy[23:0];
            pt.last = (i + 1 == n);
            case (rq.opcode)
                OP_FIXED: pt.heading = rq.fixed_heading;
                OP_AIM: begin
                    ph = aim_phase(longint'(rq.target_x) - sx, longint'(rq.target_y) - sy);
                    ph = ph + 32'h8000;
                    pt.heading = ph[31:16];
                end
                default: pt.heading = ang;
            endcase
            point_q.push_back(pt);
        end
    endtask

    function automatic t_in rand_req();
        t_in rq;
        rq.opcode = 2'($urandom_range(0, 3));
        rq.origin_x = 24'($urandom);
        rq.origin_y = 24'($urandom);
        rq.radial_offset = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 40000));
        rq.rotation = 16'($urandom);
        rq.fixed_heading = 16'($urandom);
        rq.target_x = 24'($urandom);
        rq.target_y = 24'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            rq.origin_x = 24'($signed(24'($urandom_range(0, 20000))) - 24'sd10000);
            rq.origin_y = 24'($signed(24'($urandom_range(0, 20000))) - 24'sd10000);
        end
        return rq;
    endfunction

    initial begin
        i_clk = 0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            gap_cnt <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_points(i_in);
                void'(req_q.pop_front());
            end
            if (i_valid && o_stall) begin
            end else if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                i_valid <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap_cnt <= $urandom_range(0, 10);
                i_valid <= 0;
            end else if (req_q.size() > 0) begin
                i_valid <= 1;
                i_in <= req_q[0];
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
            stall_cnt <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (point_q.size() == 0) begin
                    $error("unexpected point index %0d", o_out.point_index);
                    n_fail++;
                end else begin
                    if (o_out.point_index !== point_q[0].point_index) begin
                        $error("point_index exp %0d got %0d", point_q[0].point_index,
                               o_out.point_index);
                        n_fail++;
                    end
                    if (o_out.heading !== point_q[0].heading) begin
                        $error("heading exp %0d got %0d", point_q[0].heading, o_out.heading);
                        n_fail++;
                    end
                    if (o_out.start_x !== point_q[0].start_x) begin
                        $error("start_x exp %0d got %0d", point_q[0].start_x, o_out.start_x);
                        n_fail++;
                    end
                    if (o_out.start_y !== point_q[0].start_y) begin
                        $error("start_y exp %0d got %0d", point_q[0].start_y, o_out.start_y);
                        n_fail++;
                    end
                    if (o_out.last !== point_q[0].last) begin
                        $error("last exp %0d got %0d", point_q[0].last, o_out.last);
                        n_fail++;
                    end
                    void'(point_q.pop_front());
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_stall <= 1;
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                i_stall <= 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_cnt <= $urandom_range(0, 10);
                i_stall <= 1;
            end else begin
                i_stall <= 0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || hold_off > 0
            || (req_q.size() == 0 && point_q.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("arc_spread_point_generator regression: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(val);
        if (idx == CFG_POINT_COUNT) cfg_count = val & 8'h7f;
        else cfg_span = val & 16'hffff;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        wait (req_q.size() == 0 && !i_valid && point_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        t_in rq;
        n_fail = 0;
        calm = 0;
        hold_off = 0;
        cfg_count = 1;
        cfg_span = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        i_valid = 0;
        i_stall = 0;
        i_in = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // reset config: single point, zero span
        for (int k = 0; k < 4; k++) begin
            rq = rand_req();
            rq.opcode = 2'(k);
            req_q.push_back(rq);
        end
        rq = '0;
        rq.opcode = OP_AIM;
        req_q.push_back(rq);
        rq.origin_x = 24'h7fffff; rq.origin_y = 24'h800000;
        rq.radial_offset = 23'h7fffff; rq.rotation = 16'hffff;
        rq.fixed_heading = 16'hffff; rq.target_x = 24'h800000; rq.target_y = 24'h7fffff;
        req_q.push_back(rq);
        drain();

        write_reg(CFG_POINT_COUNT, 0);
        write_reg(CFG_ARC_SPAN, 16'hffff);
        req_q.push_back(rand_req());
        drain();

        write_reg(CFG_POINT_COUNT, 127);
        for (int k = 0; k < 4; k++) begin
            rq = rand_req();
            rq.opcode = 2'(k);
            req_q.push_back(rq);
        end
        drain();

        write_reg(CFG_POINT_COUNT, 2);
        write_reg(CFG_ARC_SPAN, 0);
        rq = rand_req();
        rq.opcode = OP_AIM;
        rq.radial_offset = 0;
        rq.target_x = rq.origin_x;
        rq.target_y = rq.origin_y;
        req_q.push_back(rq);
        req_q.push_back(rand_req());
        drain();

        // long receiver hold-off while requests keep coming
        write_reg(CFG_POINT_COUNT, 3);
        write_reg(CFG_ARC_SPAN, 16'h4000);
        hold_off = 800;
        for (int k = 0; k < 6; k++) req_q.push_back(rand_req());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_POINT_COUNT, (ph == 3) ? 64 : $urandom_range(0, 6));
            write_reg(CFG_ARC_SPAN, (ph == 5) ? 0 : $urandom);
            if (ph == 6) calm = 1;
            for (int k = 0; k < N_RANDOM / 8; k++) req_q.push_back(rand_req());
            drain();
        end

        if (n_fail == 0 && point_q.size() == 0) begin
            $display("arc_spread_point_generator regression: pass");
        end else begin
            $display("arc_spread_point_generator regression: fail");
        end
        $finish;
    end
endmodule

/* sim.f */
src/asp_pkg.sv
src/asp_ctrl.sv
src/asp_dp.sv
src/arc_spread_point_generator.sv
tb/sv/tb.sv
